[rtl/flcr_pkg.sv]
`default_nettype none

package flcr_pkg;

  localparam int ADDR_BITS    = 20;
  localparam int LEN_BITS     = ADDR_BITS + 1;
  localparam int SUM_BITS     = ADDR_BITS + 2;
  localparam int DefCapacity  = 64;

  typedef enum logic [1:0] {
    OP_APPEND  = 2'd0,
    OP_RELEASE = 2'd1,
    OP_DUMP    = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH,
    S_LO,
    S_HI,
    S_SHUP,
    S_LEN1,
    S_LEN2,
    S_UPD,
    S_SHDN,
    S_RESP,
    S_DUMP_RD,
    S_DUMP_LD
  } state_e;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [LEN_BITS-1:0]  len;
  } entry_t;

  // clamp a grown length to all ones
  function automatic logic [LEN_BITS-1:0] sat_len(input logic [SUM_BITS-1:0] v);
    logic [LEN_BITS-1:0] r;
    r = v[LEN_BITS] ? {LEN_BITS{1'b1}} : v[LEN_BITS-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/flcr_ram.sv]
`default_nettype none

module flcr_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/free_list_coalescing_release_top.sv]
`default_nettype none

// Address-ordered free list with coalescing. Keeps up to CAPACITY free blocks
// (start, length) in one entry RAM with a single write port and a registered
// read port; the RAM is not cleared after reset and only entries below the
// count are ever used. One beat is taken at a time (in_ready_o is high only
// when idle). Append and unused codes go through S_RESP to their result beat.
// Release walks the table from entry 0, one entry per cycle, until the first
// start above block_addr, then checks the neighbor ends in S_LO and S_HI,
// forms the merged length in S_LEN1 and, for a double merge, S_LEN2 (all
// through one shared 22-bit adder), and finally moves entries up (insert) or
// down (double merge) one per cycle. The walk stops where the moves begin, so
// each entry is touched about once.
// Dump loads each entry into the output register in S_DUMP_LD, after a read
// in S_DUMP_RD for all but the first, last_o marking the final one.
// Rate is set by the single RAM read port, used for both the search walk
// and the entry moves. Output sits in a register, so a result beat may wait
// for out_ready_i while the block goes back to idle.
module free_list_coalescing_release_top #(
  parameter int CAPACITY = flcr_pkg::DefCapacity
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [1:0]                     operation_i,
  input  wire logic [flcr_pkg::ADDR_BITS-1:0] block_addr_i,
  input  wire logic [flcr_pkg::LEN_BITS-1:0]  block_size_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [flcr_pkg::ADDR_BITS-1:0]      entry_addr_o,
  output logic [flcr_pkg::LEN_BITS-1:0]       entry_size_o,
  output logic                                last_o,
  output logic [1:0]                          status_o
);

  import flcr_pkg::*;

  localparam int IdxW = $clog2(CAPACITY);
  localparam int CntW = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] CapN = CntW'(CAPACITY);

  state_e state_q, state_d;

  logic [CntW-1:0] n_q, n_d;     // live entry count
  logic [CntW-1:0] p_q, p_d;     // insertion point / dump index
  logic [CntW-1:0] j_q, j_d;     // move index
  logic            low_q, low_d;
  logic            high_q, high_d;
  status_e         st_q, st_d;

  logic [ADDR_BITS-1:0] addr_q, addr_d;
  logic [LEN_BITS-1:0]  size_q, size_d;
  logic [LEN_BITS-1:0]  acc_q, acc_d;
  entry_t               prev_q, prev_d;
  entry_t               cur_q, cur_d;

  logic                 out_valid_q, out_valid_d;
  logic [ADDR_BITS-1:0] out_addr_q, out_addr_d;
  logic [LEN_BITS-1:0]  out_size_q, out_size_d;
  logic                 out_last_q, out_last_d;
  status_e              out_st_q, out_st_d;

  // entry RAM port
  logic            we;
  logic [IdxW-1:0] waddr;
  entry_t          wdata;
  logic [IdxW-1:0] raddr;
  entry_t          rdata;

  // shared adder
  logic [SUM_BITS-1:0] add_a, add_b, add_sum;

  logic            in_fire, out_free;
  logic            above, lo_hit, hi_hit;
  logic [CntW-1:0] p_inc, p_dec, j_inc, j_dec, j_m2, j_p2, n_inc, n_dec;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign out_free   = ~out_valid_q | out_ready_i;

  assign p_inc = p_q + CntW'(1);
  assign p_dec = p_q - CntW'(1);
  assign j_inc = j_q + CntW'(1);
  assign j_dec = j_q - CntW'(1);
  assign j_m2  = j_q - CntW'(2);
  assign j_p2  = j_q + CntW'(2);
  assign n_inc = n_q + CntW'(1);
  assign n_dec = n_q - CntW'(1);

  assign add_sum = add_a + add_b;
  assign above   = (rdata.start > addr_q);
  assign lo_hit  = (p_q != '0) && (add_sum == {2'b00, addr_q});
  assign hi_hit  = (p_q != n_q) && (add_sum == {2'b00, cur_q.start});

  flcr_ram #(
    .Width ($bits(entry_t)),
    .Depth (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // adder operand select
  always_comb begin
    add_a = '0;
    add_b = '0;
    case (state_q)
      S_LO: begin
        add_a = {2'b00, prev_q.start};
        add_b = {1'b0, prev_q.len};
      end
      S_HI: begin
        add_a = {2'b00, addr_q};
        add_b = {1'b0, size_q};
      end
      S_LEN1: begin
        add_a = low_q ? {1'b0, prev_q.len} : {1'b0, cur_q.len};
        add_b = {1'b0, size_q};
      end
      S_LEN2: begin
        add_a = {1'b0, acc_q};
        add_b = {1'b0, cur_q.len};
      end
      default: begin
        add_a = '0;
        add_b = '0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (op_e'(operation_i))
            OP_RELEASE: state_d = S_SRCH;
            OP_DUMP:    state_d = (n_q == '0) ? S_RESP : S_DUMP_LD;
            default:    state_d = S_RESP;
          endcase
        end
      end
      S_SRCH: begin
        if (n_q == '0 || above || p_inc == n_q) begin
          state_d = S_LO;
        end
      end
      S_LO: state_d = S_HI;
      S_HI: begin
        if (low_q || hi_hit) begin
          state_d = S_LEN1;
        end else if (n_q == CapN) begin
          state_d = S_RESP;
        end else begin
          state_d = S_SHUP;
        end
      end
      S_SHUP: begin
        if (j_q == p_q) begin
          state_d = S_RESP;
        end
      end
      S_LEN1: state_d = (low_q && high_q) ? S_LEN2 : S_UPD;
      S_LEN2: state_d = S_UPD;
      S_UPD:  state_d = (low_q && high_q) ? S_SHDN : S_RESP;
      S_SHDN: begin
        if (j_inc == n_q) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_DUMP_RD: state_d = S_DUMP_LD;
      S_DUMP_LD: begin
        if (out_free) begin
          state_d = (p_inc == n_q) ? S_IDLE : S_DUMP_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    n_d         = n_q;
    p_d         = p_q;
    j_d         = j_q;
    low_d       = low_q;
    high_d      = high_q;
    st_d        = st_q;
    addr_d      = addr_q;
    size_d      = size_q;
    acc_d       = acc_q;
    prev_d      = prev_q;
    cur_d       = cur_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_addr_d  = out_addr_q;
    out_size_d  = out_size_q;
    out_last_d  = out_last_q;
    out_st_d    = out_st_q;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;
    raddr       = '0;

    case (state_q)
      S_IDLE: begin
        raddr = '0;
        if (in_fire) begin
          addr_d = block_addr_i;
          size_d = block_size_i;
          p_d    = '0;
          st_d   = ST_OK;
          case (op_e'(operation_i))
            OP_APPEND: begin
              if (n_q == CapN) begin
                st_d = ST_FULL;
              end else begin
                we    = 1'b1;
                waddr = n_q[IdxW-1:0];
                wdata = '{start: block_addr_i, len: block_size_i};
                n_d   = n_inc;
              end
            end
            OP_DUMP: begin
              if (n_q == '0) begin
                st_d = ST_EMPTY;
              end
            end
            default: st_d = ST_OK;
          endcase
        end
      end
      S_SRCH: begin
        raddr = p_inc[IdxW-1:0];
        if (n_q != '0) begin
          if (above) begin
            cur_d = rdata;
          end else begin
            prev_d = rdata;
            p_d    = p_inc;
          end
        end
      end
      S_LO: begin
        low_d = lo_hit;
      end
      S_HI: begin
        high_d = hi_hit;
        raddr  = n_dec[IdxW-1:0];
        j_d    = n_q;
        if (!(low_q || hi_hit) && n_q == CapN) begin
          st_d = ST_FULL;
        end
      end
      S_SHUP: begin
        raddr = j_m2[IdxW-1:0];
        we    = 1'b1;
        if (j_q == p_q) begin
          waddr = p_q[IdxW-1:0];
          wdata = '{start: addr_q, len: size_q};
          n_d   = n_inc;
        end else begin
          waddr = j_q[IdxW-1:0];
          wdata = rdata;
          j_d   = j_dec;
        end
      end
      S_LEN1, S_LEN2: begin
        acc_d = sat_len(add_sum);
      end
      S_UPD: begin
        we    = 1'b1;
        raddr = p_inc[IdxW-1:0];
        j_d   = p_q;
        if (low_q) begin
          waddr = p_dec[IdxW-1:0];
          wdata = '{start: prev_q.start, len: acc_q};
        end else begin
          waddr = p_q[IdxW-1:0];
          wdata = '{start: addr_q, len: acc_q};
        end
      end
      S_SHDN: begin
        raddr = j_p2[IdxW-1:0];
        if (j_inc == n_q) begin
          n_d = n_dec;
        end else begin
          we    = 1'b1;
          waddr = j_q[IdxW-1:0];
          wdata = rdata;
          j_d   = j_inc;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_addr_d  = '0;
          out_size_d  = '0;
          out_last_d  = 1'b1;
          out_st_d    = st_q;
        end
      end
      S_DUMP_RD: begin
        raddr = p_q[IdxW-1:0];
      end
      S_DUMP_LD: begin
        raddr = p_q[IdxW-1:0];
        if (out_free) begin
          out_valid_d = 1'b1;
          out_addr_d  = rdata.start;
          out_size_d  = rdata.len;
          out_last_d  = (p_inc == n_q);
          out_st_d    = ST_OK;
          p_d         = p_inc;
        end
      end
      default: begin
        raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      n_q         <= '0;
      p_q         <= '0;
      j_q         <= '0;
      low_q       <= 1'b0;
      high_q      <= 1'b0;
      st_q        <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      p_q         <= p_d;
      j_q         <= j_d;
      low_q       <= low_d;
      high_q      <= high_d;
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    size_q     <= size_d;
    acc_q      <= acc_d;
    prev_q     <= prev_d;
    cur_q      <= cur_d;
    out_addr_q <= out_addr_d;
    out_size_q <= out_size_d;
    out_last_q <= out_last_d;
    out_st_q   <= out_st_d;
  end

  assign out_valid_o  = out_valid_q;
  assign entry_addr_o = out_addr_q;
  assign entry_size_o = out_size_q;
  assign last_o       = out_last_q;
  assign status_o     = out_st_q;

endmodule

`default_nettype wire

[rtl/flcr_checker.sv]
`default_nettype none

module flcr_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid_i,
  input wire logic                           in_ready_o,
  input wire logic                           out_valid_o,
  input wire logic                           out_ready_i,
  input wire logic [flcr_pkg::ADDR_BITS-1:0] entry_addr_o,
  input wire logic [flcr_pkg::LEN_BITS-1:0]  entry_size_o,
  input wire logic                           last_o,
  input wire logic [1:0]                     status_o
);

  import flcr_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(entry_addr_o)
      && $stable(entry_size_o) && $stable(last_o) && $stable(status_o))
    else $error("result beat changed while stalled");

  // one item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again right after accept");

  // error beats are single, final and carry no entry
  a_err_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> last_o && entry_addr_o == '0
      && entry_size_o == '0)
    else $error("error beat with entry data or not last");

  // only dump beats can be non-final
  a_mid_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> status_o == ST_OK)
    else $error("non-final beat with error status");

endmodule

bind free_list_coalescing_release_top flcr_checker u_flcr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .entry_addr_o (entry_addr_o),
  .entry_size_o (entry_size_o),
  .last_o       (last_o),
  .status_o     (status_o)
);

`default_nettype wire
